[rtl/core/dtl_pkg.sv]
package dtl_pkg;

  localparam int unsigned TorqueW  = 21;
  localparam int unsigned SpeedW   = 18;
  localparam int unsigned CfgW     = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned EnW      = 2;
  // power cap: quotient floor(2*P*r / (125*|v|)), only values below 2^20 matter
  localparam int unsigned DivSteps = 20;
  localparam int unsigned ProdW    = 2 * CfgW;          // P*r
  localparam int unsigned NumW     = ProdW + 1;         // 2*P*r
  localparam int unsigned DenW     = 24;                // 125*|v| < 2^24
  localparam int unsigned DshW     = DenW + DivSteps - 1;
  localparam int unsigned FastW    = 28;                // 1000*|v|

  localparam logic [CfgW-1:0] TireRadiusRst = 20'd250000;

  typedef enum logic [CfgIdxW-1:0] {
    RegTireRadius  = 3'd0,
    RegDriveEnv    = 3'd1,
    RegBrakeEnv    = 3'd2,
    RegEngDrive    = 3'd3,
    RegEngBrake    = 3'd4,
    RegDrivePower  = 3'd5,
    RegBrakePower  = 3'd6,
    RegPowerEn     = 3'd7
  } dtl_reg_e;

  typedef struct packed {
    logic [CfgW-1:0] tire_radius;
    logic [CfgW-1:0] drive_env;
    logic [CfgW-1:0] brake_env;
    logic [CfgW-1:0] eng_drive;
    logic [CfgW-1:0] eng_brake;
    logic [CfgW-1:0] drive_power;
    logic [CfgW-1:0] brake_power;
    logic [EnW-1:0]  power_en;
  } dtl_cfg_t;

  // one word in flight through the divider pipe
  typedef struct packed {
    logic signed [TorqueW-1:0] req;
    logic                      fast;
    logic [DenW-1:0]           den;
    logic [DshW-1:0]           dsh;
    logic [NumW-1:0]           rem_d;
    logic [NumW-1:0]           rem_b;
    logic [DivSteps-1:0]       quo_d;
    logic [DivSteps-1:0]       quo_b;
    logic                      sat_d;
    logic                      sat_b;
  } dtl_div_t;

endpackage

[rtl/core/dtl_req_if.sv]
interface dtl_req_if import dtl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TorqueW-1:0] torque_request;
  logic signed [SpeedW-1:0]  speed;

  modport source (output valid, output torque_request, output speed, input ready);
  modport sink (input valid, input torque_request, input speed, output ready);
endinterface

[rtl/core/dtl_res_if.sv]
interface dtl_res_if import dtl_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [TorqueW-1:0] torque_limited;

  modport source (output valid, output torque_limited, input ready);
  modport sink (input valid, input torque_limited, output ready);
endinterface

[rtl/core/dtl_cfg_regs.sv]
module dtl_cfg_regs import dtl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  output dtl_cfg_t           cfg_o
);

  dtl_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (dtl_reg_e'(cfg_idx_i))
        RegTireRadius: cfg_d.tire_radius = cfg_data_i;
        RegDriveEnv:   cfg_d.drive_env   = cfg_data_i;
        RegBrakeEnv:   cfg_d.brake_env   = cfg_data_i;
        RegEngDrive:   cfg_d.eng_drive   = cfg_data_i;
        RegEngBrake:   cfg_d.eng_brake   = cfg_data_i;
        RegDrivePower: cfg_d.drive_power = cfg_data_i;
        RegBrakePower: cfg_d.brake_power = cfg_data_i;
        RegPowerEn:    cfg_d.power_en    = cfg_data_i[EnW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{tire_radius: TireRadiusRst, default: '0};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/dtl_div_stage.sv]
// One restoring step for both the drive and the brake quotient.
module dtl_div_stage import dtl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     en_i,
  input  logic     vld_i,
  input  dtl_div_t item_i,
  output logic     vld_o,
  output dtl_div_t item_o
);

  dtl_div_t item_d, item_q;
  logic     vld_q;
  logic     take_d, take_b;

  always_comb begin
    item_d = item_i;
    take_d = {{(DshW-NumW){1'b0}}, item_i.rem_d} >= item_i.dsh;
    take_b = {{(DshW-NumW){1'b0}}, item_i.rem_b} >= item_i.dsh;
    // divisor fits the remainder width whenever it is subtracted
    if (take_d) begin
      item_d.rem_d = item_i.rem_d - item_i.dsh[NumW-1:0];
    end
    if (take_b) begin
      item_d.rem_b = item_i.rem_b - item_i.dsh[NumW-1:0];
    end
    item_d.quo_d = {item_i.quo_d[DivSteps-2:0], take_d};
    item_d.quo_b = {item_i.quo_b[DivSteps-2:0], take_b};
    item_d.dsh   = item_i.dsh >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

[rtl/core/drivetrain_torque_limiter_core.sv]
// Wheel torque limiter: clamps each request to [-brake limit, +drive limit], where each
// limit is min(envelope, engine limit at wheel) and, with its enable set and the wheel
// above 1 rad/s, also capped by power / wheel speed. One word is accepted per cycle while
// the result side does not stall. The power-cap divider resolves one quotient bit per
// stage over 20 stages, behind an input stage, a multiply stage and a divider setup stage,
// and ahead of the clamp and output register. A stall on the result side holds the whole
// pipeline. The user must write registers only while no word is in flight; the block
// itself does not enforce this.
module drivetrain_torque_limiter_core import dtl_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  dtl_req_if.sink            req_i,
  dtl_res_if.source          res_o
);

  dtl_cfg_t cfg;

  dtl_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  logic adv;
  logic out_vld_q;
  logic signed [TorqueW-1:0] out_tq_q, out_tq_d;

  assign adv         = ~out_vld_q | res_o.ready;
  assign req_i.ready = adv;

  // stage 1: input register, speed magnitude
  logic                      s1_vld_q;
  logic signed [TorqueW-1:0] s1_req_q;
  logic [SpeedW-1:0]         s1_abs_q, s1_abs_d, spd_raw;

  assign spd_raw  = req_i.speed;
  assign s1_abs_d = spd_raw[SpeedW-1] ? (~spd_raw + {{(SpeedW-1){1'b0}}, 1'b1}) : spd_raw;

  // stage 2: products
  logic                      s2_vld_q;
  logic signed [TorqueW-1:0] s2_req_q;
  logic                      s2_fast_q, s2_fast_d;
  logic [DenW-1:0]           s2_den_q, s2_den_d;
  logic [NumW-1:0]           s2_num_d_q, s2_num_b_q;
  logic [FastW-1:0]          spd_k;
  logic [ProdW-1:0]          prod_d, prod_b;

  assign spd_k     = FastW'(s1_abs_q) * FastW'(1000);
  assign s2_fast_d = spd_k > {{(FastW-CfgW){1'b0}}, cfg.tire_radius};
  assign s2_den_d  = DenW'(s1_abs_q) * DenW'(125);
  assign prod_d    = ProdW'(cfg.drive_power) * ProdW'(cfg.tire_radius);
  assign prod_b    = ProdW'(cfg.brake_power) * ProdW'(cfg.tire_radius);

  // stage 3: divider setup; quotients of 2^20 or more never bind
  logic                          ent_vld_q;
  dtl_div_t                      ent_q, ent_d;
  logic [DenW+DivSteps-1:0]      den_top;

  assign den_top = {s2_den_q, {DivSteps{1'b0}}};

  always_comb begin
    ent_d       = '0;
    ent_d.req   = s2_req_q;
    ent_d.fast  = s2_fast_q;
    ent_d.den   = s2_den_q;
    ent_d.dsh   = {s2_den_q, {(DivSteps-1){1'b0}}};
    ent_d.rem_d = s2_num_d_q;
    ent_d.rem_b = s2_num_b_q;
    ent_d.sat_d = {{(DenW+DivSteps-NumW){1'b0}}, s2_num_d_q} >= den_top;
    ent_d.sat_b = {{(DenW+DivSteps-NumW){1'b0}}, s2_num_b_q} >= den_top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      ent_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q  <= req_i.valid;
      s2_vld_q  <= s1_vld_q;
      ent_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_req_q   <= req_i.torque_request;
      s1_abs_q   <= s1_abs_d;
      s2_req_q   <= s1_req_q;
      s2_fast_q  <= s2_fast_d;
      s2_den_q   <= s2_den_d;
      s2_num_d_q <= {prod_d, 1'b0};
      s2_num_b_q <= {prod_b, 1'b0};
      ent_q      <= ent_d;
    end
  end

  // divider pipe, one quotient bit per stage
  logic     div_vld  [DivSteps+1];
  dtl_div_t div_item [DivSteps+1];

  assign div_vld[0]  = ent_vld_q;
  assign div_item[0] = ent_q;

  for (genvar k = 0; k < DivSteps; k++) begin : g_div
    dtl_div_stage u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .vld_i  (div_vld[k]),
      .item_i (div_item[k]),
      .vld_o  (div_vld[k+1]),
      .item_o (div_item[k+1])
    );
  end

  // clamp
  dtl_div_t               fin;
  logic [CfgW-1:0]        drv_st, brk_st, drv_lim, brk_lim;
  logic signed [TorqueW:0] clamp, hi, lo;

  assign fin    = div_item[DivSteps];
  assign drv_st = (cfg.drive_env < cfg.eng_drive) ? cfg.drive_env : cfg.eng_drive;
  assign brk_st = (cfg.brake_env < cfg.eng_brake) ? cfg.brake_env : cfg.eng_brake;

  always_comb begin
    drv_lim = drv_st;
    brk_lim = brk_st;
    if (fin.fast && cfg.power_en[0] && !fin.sat_d && (fin.quo_d < drv_st)) begin
      drv_lim = fin.quo_d;
    end
    if (fin.fast && cfg.power_en[1] && !fin.sat_b && (fin.quo_b < brk_st)) begin
      brk_lim = fin.quo_b;
    end
    hi    = $signed({2'b00, drv_lim});
    lo    = -$signed({2'b00, brk_lim});
    clamp = {fin.req[TorqueW-1], fin.req};
    if (clamp > hi) begin
      clamp = hi;
    end
    if (clamp < lo) begin
      clamp = lo;
    end
    out_tq_d = clamp[TorqueW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= div_vld[DivSteps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_tq_q <= out_tq_d;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.torque_limited = out_tq_q;

`ifndef ASSERT_OFF
  // a result word only appears when the last divider stage held one
  a_out_from_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(div_vld[DivSteps]))
    else $error("result word without a word at the divider output");

  // a stalled result freezes the word behind it
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !res_o.ready) |=> ($stable(div_vld[DivSteps]) &&
      (!div_vld[DivSteps] || $stable(fin))))
    else $error("divider output moved during a stall");

  // a non-saturated quotient leaves a fully reduced remainder
  a_rem_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld[DivSteps] && !fin.sat_d) |-> ({{(DenW+1){1'b0}}, fin.rem_d} <
      {{(NumW+1){1'b0}}, fin.den}))
    else $error("drive power quotient remainder not reduced");

  a_rem_brake: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld[DivSteps] && !fin.sat_b) |-> ({{(DenW+1){1'b0}}, fin.rem_b} <
      {{(NumW+1){1'b0}}, fin.den}))
    else $error("brake power quotient remainder not reduced");
`endif

endmodule
